[rtl/core/env_sensor_integer_compensation_defines.svh]
// Assertion macros shared by the sensor compensation RTL
`ifndef ENV_SENSOR_INTEGER_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_INTEGER_COMPENSATION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ESIC_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("esic assertion failed");

// next-cycle implication, disabled in reset
`define ESIC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("esic assertion failed");

`endif

[rtl/core/esic_pkg.sv]
// Shared types and constants of the sensor compensation pipeline
`default_nettype none
package esic_pkg;

	localparam int RAW_TP_W   = 20;
	localparam int RAW_H_W    = 16;
	localparam int TEMP_W     = 22;
	localparam int PRESS_W    = 32;
	localparam int HUM_W      = 17;
	localparam int FINE_W     = 26;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int FINE_T_P_OFS = 128000;
	localparam int P_BASE       = 1048576;
	localparam int P_SCALE      = 3125;
	localparam int FINE_T_H_OFS = 76800;
	localparam int H_MAX        = 419430400;
	localparam int H_ROUND      = 16384;
	localparam int H_BIAS       = 2097152;
	localparam int H_HALF       = 32768;
	localparam int H_ROUND2     = 8192;

	localparam logic [HUM_W-1:0] HUM_MAX_Q = HUM_W'(H_MAX / 4096);
	localparam logic [63:0]      OFS47     = 64'h0000_8000_0000_0000;

	// divider geometry: 64-bit dividend, divisor magnitude below 2^31
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 32;

	// latencies in cycles
	localparam int TEMP_FINE_LAT  = 4;
	localparam int TEMP_OUT_LAT   = 5;
	localparam int HUM_LAT        = 12;
	localparam int PRESS_PRE_LAT  = 7;
	localparam int PRESS_POST_LAT = 8;
	localparam int PRESS_LAT      = PRESS_PRE_LAT + DIV_NUM_W + PRESS_POST_LAT;
	localparam int PIPE_LAT       = TEMP_FINE_LAT + PRESS_LAT;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP     = 3'd0,
		REG_PRESS_LO = 3'd1,
		REG_PRESS_HI = 3'd2,
		REG_MIXED    = 3'd3,
		REG_HUM      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
		logic        [7:0]  h1;
		logic signed [15:0] h2;
		logic        [7:0]  h3;
		logic signed [15:0] h4;
		logic signed [15:0] h5;
		logic signed [7:0]  h6;
	} coef_t;

	typedef struct packed {
		logic neg;
		logic inv;
	} div_side_t;

endpackage
`default_nettype wire

[rtl/core/esic_if.sv]
// Channel interfaces: raw sample word, result word, configuration write
`default_nettype none
interface esic_in_if import esic_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [RAW_TP_W-1:0] raw_temperature;
	logic [RAW_TP_W-1:0] raw_pressure;
	logic [RAW_H_W-1:0]  raw_humidity;

	modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
	modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esic_out_if import esic_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic [PRESS_W-1:0]       pressure_q24_8;
	logic [HUM_W-1:0]         humidity_q22_10;
	logic                     pressure_invalid;

	modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
		pressure_invalid, input ready);
	modport sink (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
		pressure_invalid, output ready);
endinterface

interface esic_cfg_if import esic_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/env_sensor_integer_compensation.sv]
// Integer compensation of raw temperature, pressure and humidity words.
// One sample word is taken per cycle and each gives one result word; the depth
// is set by the 64-stage pressure divider (one quotient bit per stage), with 4
// fine-temperature stages ahead and 15 pressure stages around it.
// The whole pipeline advances together: it holds when the result register is full
// and not taken, otherwise it keeps accepting. Calibration registers take effect
// at once and are to be written only while no word is in flight.
`default_nettype none
`include "env_sensor_integer_compensation_defines.svh"
module env_sensor_integer_compensation import esic_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	esic_in_if.sink     sample,
	esic_out_if.source  result,
	esic_cfg_if.sink    cfg
);

	logic [47:0]         temp_q;
	logic [63:0]         plo_q;
	logic [63:0]         phi_q;
	logic [47:0]         mix_q;
	logic [39:0]         hum_q;
	coef_t               coef;
	logic [PIPE_LAT-1:0] vld_q;
	logic                en;

	logic signed [FINE_W-1:0] fine;
	logic [TEMP_W-1:0]   temp;
	logic [TEMP_W-1:0]   temp_out;
	logic [RAW_TP_W-1:0] praw;
	logic [RAW_H_W-1:0]  hraw;
	logic [HUM_W-1:0]    hum;
	logic [HUM_W-1:0]    hum_out;
	logic [PRESS_W-1:0]  pressure;
	logic                invalid;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			plo_q  <= '0;
			phi_q  <= '0;
			mix_q  <= '0;
			hum_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TEMP:     temp_q <= cfg.data[47:0];
				REG_PRESS_LO: plo_q  <= cfg.data;
				REG_PRESS_HI: phi_q  <= cfg.data;
				REG_MIXED:    mix_q  <= cfg.data[47:0];
				REG_HUM:      hum_q  <= cfg.data[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.t1 = temp_q[15:0];
		coef.t2 = temp_q[31:16];
		coef.t3 = temp_q[47:32];
		coef.p1 = plo_q[15:0];
		coef.p2 = plo_q[31:16];
		coef.p3 = plo_q[47:32];
		coef.p4 = plo_q[63:48];
		coef.p5 = phi_q[15:0];
		coef.p6 = phi_q[31:16];
		coef.p7 = phi_q[47:32];
		coef.p8 = phi_q[63:48];
		coef.p9 = mix_q[15:0];
		coef.h1 = mix_q[23:16];
		coef.h2 = mix_q[39:24];
		coef.h3 = mix_q[47:40];
		coef.h4 = hum_q[15:0];
		coef.h5 = hum_q[31:16];
		coef.h6 = hum_q[39:32];
	end

	assign en           = !vld_q[PIPE_LAT-1] || result.ready;
	assign sample.ready = en;
	assign result.valid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], sample.valid};
		end
	end

	esic_temp u_temp (
		.clk   (clk),
		.en    (en),
		.raw_t (sample.raw_temperature),
		.coef  (coef),
		.fine  (fine),
		.temp  (temp)
	);

	esic_dly #(.WIDTH(RAW_TP_W), .DEPTH(TEMP_FINE_LAT)) u_praw_dly (
		.clk (clk),
		.en  (en),
		.d   (sample.raw_pressure),
		.q   (praw)
	);

	esic_dly #(.WIDTH(RAW_H_W), .DEPTH(TEMP_FINE_LAT)) u_hraw_dly (
		.clk (clk),
		.en  (en),
		.d   (sample.raw_humidity),
		.q   (hraw)
	);

	esic_press u_press (
		.clk      (clk),
		.en       (en),
		.fine     (fine),
		.praw     (praw),
		.coef     (coef),
		.pressure (pressure),
		.invalid  (invalid)
	);

	esic_hum u_hum (
		.clk  (clk),
		.en   (en),
		.fine (fine),
		.hraw (hraw),
		.coef (coef),
		.hum  (hum)
	);

	esic_dly #(.WIDTH(TEMP_W), .DEPTH(PIPE_LAT - TEMP_OUT_LAT)) u_temp_dly (
		.clk (clk),
		.en  (en),
		.d   (temp),
		.q   (temp_out)
	);

	esic_dly #(.WIDTH(HUM_W), .DEPTH(PIPE_LAT - TEMP_FINE_LAT - HUM_LAT)) u_hum_dly (
		.clk (clk),
		.en  (en),
		.d   (hum),
		.q   (hum_out)
	);

	assign result.temperature_centi = $signed(temp_out);
	assign result.pressure_q24_8    = pressure;
	assign result.humidity_q22_10   = hum_out;
	assign result.pressure_invalid  = invalid;

	// pipeline freezes on a held result
	`ESIC_ASSERT_NEXT(a_stall_freeze, clk, arst_n, !en, vld_q == $past(vld_q))
	`ESIC_ASSERT_NEXT(a_accept_fill, clk, arst_n, en && sample.valid, vld_q[0])
	`ESIC_ASSERT_IMPL(a_inv_zero, clk, arst_n, result.valid && result.pressure_invalid, result.pressure_q24_8 == '0)
	`ESIC_ASSERT_IMPL(a_hum_range, clk, arst_n, result.valid, result.humidity_q22_10 <= HUM_MAX_Q)

endmodule
`default_nettype wire

[rtl/core/esic_dly.sv]
// Enabled shift line that aligns a side path to the main pipeline
`default_nettype none
module esic_dly import esic_pkg::*; #(
	parameter int WIDTH = TEMP_W,
	parameter int DEPTH = TEMP_FINE_LAT
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] d,
	output logic      [WIDTH-1:0] q
);

	logic [WIDTH-1:0] sh_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				sh_s[i] <= sh_s[i-1];
			end
		end
	end

	assign q = sh_s[DEPTH-1];

endmodule
`default_nettype wire

[rtl/core/esic_temp.sv]
// Fine temperature and centi-degree temperature, five stages
`default_nettype none
module esic_temp import esic_pkg::*; (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [RAW_TP_W-1:0] raw_t,
	input  wire coef_t               coef,
	output logic signed [FINE_W-1:0] fine,
	output logic signed [TEMP_W-1:0] temp
);

	logic signed [17:0]       d1_s1;
	logic signed [16:0]       d2_s1;
	logic signed [33:0]       m1_s2;
	logic signed [33:0]       sq_s2;
	logic signed [22:0]       tm1_s3;
	logic signed [37:0]       m2_s3;
	logic signed [FINE_W-1:0] fine_s4;
	logic signed [FINE_W+2:0] t5;
	logic signed [TEMP_W-1:0] temp_s5;

	assign t5 = (FINE_W+3)'((FINE_W+3)'(fine_s4) * 5 + 128);

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1   <= $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
			d2_s1   <= $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, coef.t1});
			m1_s2   <= 34'(d1_s1) * 34'($signed(coef.t2));
			sq_s2   <= 34'(d2_s1) * 34'(d2_s1);
			tm1_s3  <= 23'(m1_s2 >>> 11);
			m2_s3   <= 38'(sq_s2 >>> 12) * 38'($signed(coef.t3));
			fine_s4 <= FINE_W'(tm1_s3) + FINE_W'(m2_s3 >>> 14);
			temp_s5 <= TEMP_W'(t5 >>> 8);
		end
	end

	assign fine = fine_s4;
	assign temp = temp_s5;

endmodule
`default_nettype wire

[rtl/core/esic_div.sv]
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module esic_div import esic_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	input  wire div_side_t            side_in,
	output logic      [DIV_NUM_W-1:0] quot,
	output div_side_t                 side_out
);

	// nq_s holds the unshifted dividend bits high and quotient bits low
	logic [DIV_NUM_W-1:0] nq_s   [DIV_NUM_W];
	logic [DIV_DEN_W-1:0] rem_s  [DIV_NUM_W];
	logic [DIV_DEN_W-1:0] den_s  [DIV_NUM_W];
	div_side_t            side_s [DIV_NUM_W];

	for (genvar i = 0; i < DIV_NUM_W; i++) begin : g_stage
		logic [DIV_DEN_W-1:0] rem_in;
		logic [DIV_DEN_W-1:0] den_in;
		logic [DIV_NUM_W-1:0] nq_in;
		div_side_t            side_i;
		logic [DIV_DEN_W:0]   trial;
		logic                 fits;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
			assign den_in = den;
			assign side_i = side_in;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign nq_in  = nq_s[i-1];
			assign den_in = den_s[i-1];
			assign side_i = side_s[i-1];
		end

		assign trial = {rem_in, nq_in[DIV_NUM_W-1]};
		assign fits  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= fits ? DIV_DEN_W'(trial - {1'b0, den_in}) : trial[DIV_DEN_W-1:0];
				nq_s[i]   <= {nq_in[DIV_NUM_W-2:0], fits};
				den_s[i]  <= den_in;
				side_s[i] <= side_i;
			end
		end
	end

	assign quot     = nq_s[DIV_NUM_W-1];
	assign side_out = side_s[DIV_NUM_W-1];

endmodule
`default_nettype wire

[rtl/core/esic_press.sv]
// Pressure path: 64-bit wrapping datapath around the pipelined divider
`default_nettype none
module esic_press import esic_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [FINE_W-1:0] fine,
	input  wire logic [RAW_TP_W-1:0]  praw,
	input  wire coef_t                coef,
	output logic [PRESS_W-1:0]        pressure,
	output logic                      invalid
);

	// ahead of the divider
	logic signed [26:0] a_s1;
	logic [20:0]        pb_s1, pb_s2, pb_s3, pb_s4;
	logic signed [53:0] aa_s2;
	logic signed [42:0] ap5_s2, ap2_s2, ap5_s3, ap2_s3;
	logic signed [63:0] t6_s3, t3_s3, b_s4, a2_s4;
	logic [63:0]        a2b_s5, pn_s5, m_s6, num_s6;
	logic signed [30:0] dv;
	logic signed [31:0] dx;
	logic [DIV_NUM_W-1:0] nm_s7;
	logic [DIV_DEN_W-1:0] dm_s7;
	div_side_t          side_s7;

	// after the divider
	logic [DIV_NUM_W-1:0] qm;
	div_side_t          side_d;
	logic signed [63:0] q_s8, q_s9, q_s10, q_s11, q_s12, sp;
	logic [63:0]        ll_s9, ss_s10;
	logic [30:0]        lh_s9;
	logic signed [63:0] e_s9, e2_s10, e2_s11, e2_s12, cp_s11, c_s12, sum_s13, r_s14;
	logic               inv_s8, inv_s9, inv_s10, inv_s11, inv_s12, inv_s13, inv_s14;
	logic [PRESS_W-1:0] pressure_s15;
	logic               invalid_s15;

	assign dv = $signed(m_s6[63:33]);
	assign dx = 32'(dv);
	assign sp = q_s8 >>> 13;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= 27'(fine) - 27'(FINE_T_P_OFS);
			pb_s1   <= 21'(P_BASE) - {1'b0, praw};
			aa_s2   <= 54'(a_s1) * 54'(a_s1);
			ap5_s2  <= 43'(a_s1) * 43'($signed(coef.p5));
			ap2_s2  <= 43'(a_s1) * 43'($signed(coef.p2));
			pb_s2   <= pb_s1;
			t6_s3   <= 64'(aa_s2) * 64'($signed(coef.p6));
			t3_s3   <= 64'(aa_s2) * 64'($signed(coef.p3));
			ap5_s3  <= ap5_s2;
			ap2_s3  <= ap2_s2;
			pb_s3   <= pb_s2;
			b_s4    <= t6_s3 + (64'(ap5_s3) <<< 17) + (64'($signed(coef.p4)) <<< 35);
			a2_s4   <= (t3_s3 >>> 8) + (64'(ap2_s3) <<< 12);
			pb_s4   <= pb_s3;
			a2b_s5  <= a2_s4 + OFS47;
			pn_s5   <= {12'b0, pb_s4, 31'b0} - b_s4;
			m_s6    <= a2b_s5 * {48'b0, coef.p1};
			num_s6  <= pn_s5 * 64'(P_SCALE);
			nm_s7   <= num_s6[63] ? (64'd0 - num_s6) : num_s6;
			dm_s7   <= dx[31] ? (32'd0 - dx) : dx;
			side_s7 <= '{neg: num_s6[63] ^ dv[30], inv: (dv == '0)};
		end
	end

	esic_div u_div (
		.clk      (clk),
		.en       (en),
		.num      (nm_s7),
		.den      (dm_s7),
		.side_in  (side_s7),
		.quot     (qm),
		.side_out (side_d)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s8         <= side_d.neg ? $signed(64'd0 - qm) : $signed(qm);
			inv_s8       <= side_d.inv;
			// low 64 bits of sp*sp from 32-bit partial products
			ll_s9        <= 64'(sp[31:0]) * 64'(sp[31:0]);
			lh_s9        <= 31'(sp[31:0] * sp[63:32]);
			e_s9         <= q_s8 * 64'($signed(coef.p8));
			q_s9         <= q_s8;
			inv_s9       <= inv_s8;
			ss_s10       <= ll_s9 + {lh_s9, 33'b0};
			e2_s10       <= e_s9 >>> 19;
			q_s10        <= q_s9;
			inv_s10      <= inv_s9;
			cp_s11       <= $signed(ss_s10) * 64'($signed(coef.p9));
			e2_s11       <= e2_s10;
			q_s11        <= q_s10;
			inv_s11      <= inv_s10;
			c_s12        <= cp_s11 >>> 25;
			e2_s12       <= e2_s11;
			q_s12        <= q_s11;
			inv_s12      <= inv_s11;
			sum_s13      <= q_s12 + c_s12 + e2_s12;
			inv_s13      <= inv_s12;
			r_s14        <= (sum_s13 >>> 8) + (64'($signed(coef.p7)) <<< 4);
			inv_s14      <= inv_s13;
			invalid_s15  <= inv_s14;
			if (inv_s14 || r_s14[63]) begin
				pressure_s15 <= '0;
			end else if (|r_s14[62:32]) begin
				pressure_s15 <= '1;
			end else begin
				pressure_s15 <= r_s14[31:0];
			end
		end
	end

	assign pressure = pressure_s15;
	assign invalid  = invalid_s15;

endmodule
`default_nettype wire

[rtl/core/esic_hum.sv]
// Humidity path: 32-bit wrapping datapath, twelve stages
`default_nettype none
module esic_hum import esic_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [FINE_W-1:0] fine,
	input  wire logic [RAW_H_W-1:0]   hraw,
	input  wire coef_t                coef,
	output logic [HUM_W-1:0]          hum
);

	logic signed [31:0] v_s1;
	logic [RAW_H_W-1:0] hr_s1;
	logic signed [31:0] vh5_s2, vh6_s2, vh3_s2, xa_s2;
	logic signed [31:0] x_s3, x_s4, x_s5, x_s6, x_s7;
	logic signed [31:0] ya_s3, yb_s3, y1_s4, y2_s5, y3_s6, y4_s7;
	logic signed [31:0] v2_s8, v2_s9, v2_s10, v2_s11;
	logic signed [31:0] x2_s9, sq_s10, t_s11, v3;
	logic [HUM_W-1:0]   hum_s12;

	assign v3 = v2_s11 - (t_s11 >>> 4);

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1   <= 32'(fine) - 32'(FINE_T_H_OFS);
			hr_s1  <= hraw;
			vh5_s2 <= v_s1 * 32'($signed(coef.h5));
			vh6_s2 <= v_s1 * 32'($signed(coef.h6));
			vh3_s2 <= v_s1 * $signed({24'b0, coef.h3});
			xa_s2  <= $signed({2'b0, hr_s1, 14'b0}) - (32'($signed(coef.h4)) <<< 20)
				+ 32'(H_ROUND);
			x_s3   <= (xa_s2 - vh5_s2) >>> 15;
			ya_s3  <= vh6_s2 >>> 10;
			yb_s3  <= (vh3_s2 >>> 11) + 32'(H_HALF);
			y1_s4  <= ya_s3 * yb_s3;
			x_s4   <= x_s3;
			y2_s5  <= (y1_s4 >>> 10) + 32'(H_BIAS);
			x_s5   <= x_s4;
			y3_s6  <= y2_s5 * 32'($signed(coef.h2));
			x_s6   <= x_s5;
			y4_s7  <= (y3_s6 + 32'(H_ROUND2)) >>> 14;
			x_s7   <= x_s6;
			v2_s8  <= x_s7 * y4_s7;
			x2_s9  <= v2_s8 >>> 15;
			v2_s9  <= v2_s8;
			sq_s10 <= x2_s9 * x2_s9;
			v2_s10 <= v2_s9;
			t_s11  <= (sq_s10 >>> 7) * $signed({24'b0, coef.h1});
			v2_s11 <= v2_s10;
			if (v3[31]) begin
				hum_s12 <= '0;
			end else if (v3 > H_MAX) begin
				hum_s12 <= HUM_MAX_Q;
			end else begin
				hum_s12 <= v3[28:12];
			end
		end
	end

	assign hum = hum_s12;

endmodule
`default_nettype wire
